// ===== hw/rtl/hata_path_loss_top_defines.svh =====
// Assertion macros shared by the path loss RTL.
`ifndef HATA_PATH_LOSS_TOP_DEFINES_SVH
`define HATA_PATH_LOSS_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define HPL_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HPL_ASSERT_NORST(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HPL_ASSERT(name, clk, rst_n, prop, msg)
`define HPL_ASSERT_NORST(name, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/hpl_pkg.sv =====
// Shared types and constants of the COST-231 Hata path loss pipeline.
package hpl_pkg;

  // Logarithm unit: input width, exponent width, Q24 result width and stage count.
  localparam int unsigned LOG_IN_W   = 15;
  localparam int unsigned LOG_EXP_W  = 4;
  localparam int unsigned LOG_OUT_W  = 27;
  localparam int unsigned LOG_STAGES = 6;

  typedef logic [LOG_IN_W-1:0]  log_in_t;
  typedef logic [LOG_OUT_W-1:0] log_out_t;

  // log10(2) in Q30.
  localparam logic [28:0] LOG10_2_Q30 = 29'd323228497;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_AREA   = 3'd1,
    ST_BAD_FREQ   = 3'd2,
    ST_BAD_BASE   = 3'd3,
    ST_BAD_MOBILE = 3'd4,
    ST_BAD_DIST   = 3'd5
  } status_e;

  localparam logic [1:0] AREA_MEDIUM = 2'd0;
  localparam logic [1:0] AREA_METRO  = 2'd1;

  localparam logic [11:0] FREQ_MIN = 12'd1500;
  localparam logic [11:0] FREQ_MAX = 12'd2000;
  localparam logic [11:0] BASE_MIN = 12'd300;
  localparam logic [11:0] BASE_MAX = 12'd2000;
  localparam logic [10:0] MOB_MIN  = 11'd100;
  localparam logic [10:0] MOB_MAX  = 11'd1000;
  localparam logic [14:0] DIST_MIN = 15'd1000;
  localparam logic [14:0] DIST_MAX = 15'd20000;

endpackage

// ===== hw/rtl/hpl_log10.sv =====
// Six-stage base-10 logarithm in Q24 by leading-one detection and table interpolation.
module hpl_log10 #(
  parameter int unsigned LOG_TABLE_ENTRIES = 64
) (
  input  logic                           clk_i,
  input  logic [hpl_pkg::LOG_STAGES-1:0] en_i,
  input  hpl_pkg::log_in_t               x_i,
  output hpl_pkg::log_out_t              log10_o
);
  import hpl_pkg::*;

  localparam int unsigned FracW = 32;
  localparam int unsigned TabW  = 25;
  localparam int unsigned IdxW  = $clog2(LOG_TABLE_ENTRIES);
  localparam int unsigned RomAw = $clog2(LOG_TABLE_ENTRIES + 1);
  localparam int unsigned ProdW = FracW + RomAw;
  localparam int unsigned IpW   = TabW + FracW;
  localparam int unsigned L2W   = LOG_EXP_W + 24;
  localparam int unsigned L10W  = 57;

  // Table entry i holds log2(1 + i/N) in Q24, built bit by bit by repeated squaring.
  function automatic logic [TabW-1:0] log_entry(input int unsigned i);
    logic [63:0] y;
    logic [23:0] bits;
    if (i >= LOG_TABLE_ENTRIES) begin
      return TabW'(64'd1 << 24);
    end
    y = (64'd1 << 30) + ((64'(i) << 30) / LOG_TABLE_ENTRIES);
    bits = '0;
    for (int k = 0; k < 24; k++) begin
      y = (y * y) >> 30;
      bits = {bits[22:0], 1'b0};
      if (y >= (64'd1 << 31)) begin
        bits[0] = 1'b1;
        y = y >> 1;
      end
    end
    return {1'b0, bits};
  endfunction

  logic [TabW-1:0] rom_w [LOG_TABLE_ENTRIES+1];

  for (genvar g = 0; g <= LOG_TABLE_ENTRIES; g++) begin : g_rom
    assign rom_w[g] = log_entry(g);
  end

  logic [LOG_EXP_W-1:0] e1_d, e1_q, e2_q, e3_q, e4_q;
  logic [FracW-1:0]     frac1_d, frac1_q;
  logic [4:0]           shift_w;
  logic [ProdW-1:0]     p2_w;
  logic [IdxW-1:0]      idx2_q;
  logic [FracW-1:0]     rem2_q, rem3_q;
  logic [RomAw-1:0]     addr_w;
  logic [TabW-1:0]      lo_w, hi_w, lo3_q, diff3_q, lo4_q, interp4_q;
  logic [IpW-1:0]       ip_w;
  logic [L2W-1:0]       l2_5_q;
  logic [L10W-1:0]      l10_w;
  logic [LOG_OUT_W-1:0] log10_q;

  // Stage 1: position of the leading one and the bits below it, left aligned.
  always_comb begin
    e1_d = '0;
    for (int b = 1; b < LOG_IN_W; b++) begin
      if (x_i[b]) begin
        e1_d = LOG_EXP_W'(b);
      end
    end
    shift_w = 5'(LOG_IN_W) - 5'(e1_d);
    frac1_d = {x_i, {(FracW-LOG_IN_W){1'b0}}} << shift_w;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      e1_q    <= e1_d;
      frac1_q <= frac1_d;
    end
  end

  // Stage 2: scale the fraction to a table index and a 32-bit remainder.
  assign p2_w = ProdW'(frac1_q) * ProdW'(LOG_TABLE_ENTRIES);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      e2_q   <= e1_q;
      idx2_q <= p2_w[FracW +: IdxW];
      rem2_q <= p2_w[FracW-1:0];
    end
  end

  // Stage 3: table lookup of both neighbors.
  assign addr_w = RomAw'(idx2_q);
  assign lo_w   = rom_w[addr_w];
  assign hi_w   = rom_w[addr_w + RomAw'(1)];

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      e3_q    <= e2_q;
      lo3_q   <= lo_w;
      diff3_q <= hi_w - lo_w;
      rem3_q  <= rem2_q;
    end
  end

  // Stage 4: linear interpolation step.
  assign ip_w = IpW'(diff3_q) * IpW'(rem3_q);

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      e4_q      <= e3_q;
      lo4_q     <= lo3_q;
      interp4_q <= ip_w[FracW +: TabW];
    end
  end

  // Stage 5: log2 in Q24.
  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      l2_5_q <= {e4_q, 24'd0} + L2W'(lo4_q) + L2W'(interp4_q);
    end
  end

  // Stage 6: convert to log10 with rounding.
  assign l10_w = L10W'(l2_5_q) * L10W'(LOG10_2_Q30) + (L10W'(1) << 29);

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      log10_q <= l10_w[30 +: LOG_OUT_W];
    end
  end

  assign log10_o = log10_q;

endmodule

// ===== hw/rtl/hata_path_loss_top.sv =====
// Top level of the streaming COST-231 Hata urban path loss pipeline.
//
//   channel   | dir | handshake                   | tdata (low bit up)             | tuser
//   ----------+-----+-----------------------------+--------------------------------+-----------
//   s_axis    | in  | s_axis_tvalid/s_axis_tready | freq, base h, mobile h, dist   | area_kind
//   m_axis    | out | m_axis_tvalid/m_axis_tready | loss_q8                        | status
//
// One word is taken per clock unless every stage is full and the output is held.
// Sixteen register stages carry a valid bit each; a stage loads whenever it is empty
// or the stage after it moves, so bubbles close up and a stall holds every word in place.
// s_axis_tready drops only when all stages are full and the output is held.
// Reset clears the valid bits only; no warm-up is needed after reset.
`include "hata_path_loss_top_defines.svh"
module hata_path_loss_top #(
  parameter int unsigned LOSS_FRAC_BITS    = 8,
  parameter int unsigned LOG_TABLE_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [11:0] freq_mhz, [23:12] base_height_dm, [34:24] mobile_height_cm,
  // [49:35] distance_m, [55:50] zero
  input  logic [55:0] s_axis_tdata,
  // [1:0] area_kind
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] loss_q8
  output logic [15:0] m_axis_tdata,
  // [2:0] status
  output logic [2:0]  m_axis_tuser
);
  import hpl_pkg::*;

  localparam int unsigned Stages   = 16;
  localparam int unsigned AccW     = 42;
  localparam int unsigned DropBits = 26 - LOSS_FRAC_BITS;
  localparam logic [AccW-1:0] HalfDiv   = AccW'(50) << (24 - LOSS_FRAC_BITS);
  localparam logic [AccW-1:0] LinBase   = AccW'(4550) << 24;
  localparam logic [AccW-1:0] MetroAdd  = AccW'(300) << 24;
  localparam logic [33:0]     A1Off     = 34'(70) << 24;
  localparam logic [32:0]     Div25Mul  = 33'd5497558138;
  localparam logic [34:0]     Div100Mul = 35'd167773;

  typedef struct packed {
    logic [10:0] hm;
    logic        metro;
    status_e     status;
  } side_t;

  // floor(y / 25) to within one below, then corrected by one compare.
  function automatic logic [27:0] div25_est(input logic [31:0] y);
    logic [64:0] p;
    p = 65'(y) * 65'(Div25Mul);
    return p[37 +: 28];
  endfunction

  function automatic logic [27:0] div25_fix(input logic [31:0] y, input logic [27:0] q);
    logic [31:0] r;
    r = y - 32'(q) * 32'd25;
    return q + 28'(r >= 32'd25);
  endfunction

  logic [Stages:0]   en;
  logic [Stages-1:0] valid_q, valid_in;
  side_t             side_d;
  side_t             side_q [Stages];

  logic [11:0] freq_w, base_w;
  logic [10:0] mob_w;
  logic [14:0] dist_w;
  logic [1:0]  area_w;

  log_out_t lf_w, lbr_w, ldr_w;

  always_comb begin
    en[Stages] = m_axis_tready;
    for (int k = Stages - 1; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[0];
  assign valid_in      = {valid_q[Stages-2:0], s_axis_tvalid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < Stages; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_in[k];
        end
      end
    end
  end

  // Stage 0: field split and range checks, in priority order.
  assign freq_w = s_axis_tdata[11:0];
  assign base_w = s_axis_tdata[23:12];
  assign mob_w  = s_axis_tdata[34:24];
  assign dist_w = s_axis_tdata[49:35];
  assign area_w = s_axis_tuser;

  always_comb begin
    side_d.hm     = mob_w;
    side_d.metro  = (area_w == AREA_METRO);
    if (area_w != AREA_MEDIUM && area_w != AREA_METRO) begin
      side_d.status = ST_BAD_AREA;
    end else if (freq_w < FREQ_MIN || freq_w > FREQ_MAX) begin
      side_d.status = ST_BAD_FREQ;
    end else if (base_w < BASE_MIN || base_w > BASE_MAX) begin
      side_d.status = ST_BAD_BASE;
    end else if (mob_w < MOB_MIN || mob_w > MOB_MAX) begin
      side_d.status = ST_BAD_MOBILE;
    end else if (dist_w < DIST_MIN || dist_w > DIST_MAX) begin
      side_d.status = ST_BAD_DIST;
    end else begin
      side_d.status = ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      side_q[0] <= side_d;
    end
    for (int k = 1; k < Stages; k++) begin
      if (en[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Stages 0 to 5: the three logarithms.
  hpl_log10 #(.LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)) u_log_freq (
    .clk_i   (clk_i),
    .en_i    (en[LOG_STAGES-1:0]),
    .x_i     (LOG_IN_W'(freq_w)),
    .log10_o (lf_w)
  );

  hpl_log10 #(.LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)) u_log_base (
    .clk_i   (clk_i),
    .en_i    (en[LOG_STAGES-1:0]),
    .x_i     (LOG_IN_W'(base_w)),
    .log10_o (lbr_w)
  );

  hpl_log10 #(.LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)) u_log_dist (
    .clk_i   (clk_i),
    .en_i    (en[LOG_STAGES-1:0]),
    .x_i     (dist_w),
    .log10_o (ldr_w)
  );

  // Stage 6: height and distance logs relative to 1 m and 1 km, and the
  // cross product of the distance slope.
  logic signed [27:0] lb_d, ld_d, lb6_q, ld6_q;
  logic        [26:0] lf6_q;
  logic        [33:0] a1_d, a1_6_q;
  logic signed [55:0] lbld_d, lbld6_q;

  always_comb begin
    lb_d   = $signed({1'b0, lbr_w}) - 28'sd16777216;
    ld_d   = $signed({1'b0, ldr_w}) - 28'sd50331648;
    a1_d   = 34'(lf_w) * 34'd110 - A1Off;
    lbld_d = 56'(lb_d) * 56'(ld_d);
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      lf6_q   <= lf_w;
      lb6_q   <= lb_d;
      ld6_q   <= ld_d;
      a1_6_q  <= a1_d;
      lbld6_q <= lbld_d;
    end
  end

  // Stage 7: estimate of a1 / 100, scaled cross term and the linear terms.
  logic        [27:0]     qa7_q;
  logic        [33:0]     a1_7_q;
  logic signed [63:0]     p655_d, p655_7_q;
  logic        [AccW-1:0] lin_d, lin7_q;

  always_comb begin
    p655_d = 64'(lbld6_q) * 64'sd655;
    lin_d  = LinBase + AccW'(lf6_q) * AccW'(3546) - AccW'(lb6_q) * AccW'(1382)
           + AccW'(ld6_q) * AccW'(4490) + (side_q[6].metro ? MetroAdd : '0);
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      qa7_q    <= div25_est(a1_6_q[33:2]);
      a1_7_q   <= a1_6_q;
      p655_7_q <= p655_d;
      lin7_q   <= lin_d;
    end
  end

  // Stage 8: corrected quotient and floor of the cross term by 2^24.
  logic        [27:0]     a8_q;
  logic        [33:0]     a1_8_q;
  logic signed [63:0]     negp_w;
  logic signed [39:0]     dterm8_q;
  logic        [AccW-1:0] lin8_q;

  assign negp_w = -p655_7_q;

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      a8_q     <= div25_fix(a1_7_q[33:2], qa7_q);
      a1_8_q   <= a1_7_q;
      dterm8_q <= 40'(negp_w >>> 24);
      lin8_q   <= lin7_q;
    end
  end

  // Stage 9: a1 = 100 A + B, so floor(a1 hm / 100) = A hm + floor(B hm / 100).
  logic [6:0]      b9_q;
  logic [38:0]     ah9_q;
  logic [AccW-1:0] s9_q;

  always_ff @(posedge clk_i) begin
    if (en[9]) begin
      b9_q  <= 7'(a1_8_q - 34'(a8_q) * 34'd100);
      ah9_q <= 39'(a8_q) * 39'(side_q[8].hm);
      s9_q  <= lin8_q + AccW'(dterm8_q);
    end
  end

  // Stage 10.
  logic [16:0]     bh10_q;
  logic [AccW-1:0] s10_q;

  always_ff @(posedge clk_i) begin
    if (en[10]) begin
      bh10_q <= 17'(b9_q) * 17'(side_q[9].hm);
      s10_q  <= s9_q - AccW'(ah9_q);
    end
  end

  // Stage 11: B hm is below 2^17, where the reciprocal of 100 is exact.
  logic [34:0]     bqp_w;
  logic [9:0]      bq11_q;
  logic [AccW-1:0] s11_q;

  assign bqp_w = 35'(bh10_q) * Div100Mul;

  always_ff @(posedge clk_i) begin
    if (en[11]) begin
      bq11_q <= bqp_w[24 +: 10];
      s11_q  <= s10_q;
    end
  end

  // Stage 12: full loss in units of 2^-24 / 100 dB.
  logic signed [AccW-1:0] acc12_q;

  always_ff @(posedge clk_i) begin
    if (en[12]) begin
      acc12_q <= $signed(s11_q - AccW'(bq11_q));
    end
  end

  // Stage 13: round half up; the division by 100 2^(24-F) is a shift then a divide by 25.
  logic signed [AccW-1:0] zs_w;
  logic [31:0]            y13_q, y14_q;
  logic                   neg13_q, neg14_q;
  logic [27:0]            q14_q;

  assign zs_w = acc12_q + $signed(HalfDiv);

  always_ff @(posedge clk_i) begin
    if (en[13]) begin
      y13_q   <= 32'(zs_w >>> DropBits);
      neg13_q <= zs_w[AccW-1];
    end
  end

  // Stage 14.
  always_ff @(posedge clk_i) begin
    if (en[14]) begin
      q14_q   <= div25_est(y13_q);
      y14_q   <= y13_q;
      neg14_q <= neg13_q;
    end
  end

  // Stage 15: output register with saturation, and zero loss for an error status.
  logic [27:0] qf_w;
  logic [15:0] loss_d, loss_q;

  always_comb begin
    qf_w = div25_fix(y14_q, q14_q);
    if (side_q[14].status != ST_OK || neg14_q) begin
      loss_d = '0;
    end else if (qf_w > 28'd65535) begin
      loss_d = 16'hFFFF;
    end else begin
      loss_d = qf_w[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[15]) begin
      loss_q <= loss_d;
    end
  end

  assign m_axis_tvalid = valid_q[Stages-1];
  assign m_axis_tdata  = loss_q;
  assign m_axis_tuser  = side_q[Stages-1].status;

  `HPL_ASSERT_NORST(a_ready_only_when_full, clk_i, !s_axis_tready |-> (&valid_q && !m_axis_tready), "input stalled while pipeline not full")
  `HPL_ASSERT(a_bad_status_zero_loss, clk_i, rst_ni, (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata == 16'd0), "nonzero loss with error status")
  `HPL_ASSERT(a_ok_status_loss, clk_i, rst_ni, (m_axis_tvalid && m_axis_tuser == ST_OK) |-> (m_axis_tdata != 16'd0), "zero loss with ok status")
  `HPL_ASSERT(a_mod100_range, clk_i, rst_ni, valid_q[9] |-> (b9_q < 7'd100), "a1 remainder by 100 out of range")

endmodule

// ===== test/testbench.sv =====
// Self-checking stream testbench for the COST-231 Hata path loss pipeline.
`timescale 1ns / 100ps

module testbench;
  import hpl_pkg::*;

  localparam int unsigned LOSS_FRAC_BITS    = 8;
  localparam int unsigned LOG_TABLE_ENTRIES = 64;
  localparam int unsigned MANT_AW           = $clog2(LOG_TABLE_ENTRIES + 1);
  localparam longint      Q24               = longint'(1) << 24;
  localparam int          RANDOM_LINKS      = 1300;
  localparam int          BURST_FIRST       = 300;
  localparam int          BURST_LAST        = 520;
  localparam int          HOLD_CYCLES       = 300;
  localparam int          QUIET_AT          = 800;
  localparam int          TAIL_CYCLES       = 32;
  localparam int          IDLE_LIMIT        = 3000;
  localparam int          DIR_ROWS          = 23;

  typedef struct packed {
    logic [11:0] freq;
    logic [11:0] base;
    logic [10:0] mob;
    logic [14:0] dist_m;
    logic [1:0]  area;
  } link_t;

  typedef struct packed {
    logic [15:0] loss;
    status_e     status;
  } loss_res_t;

  // A row either carries a typed range error (loss 0) or is left to the predictor.
  typedef struct packed {
    link_t   ln;
    logic    typed;
    status_e status;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  loss_res_t       offered_loss;
  logic            hold_req;
  loss_res_t       pending_losses[$];
  loss_res_t       seen;
  longint unsigned log2_mant_q24 [0:LOG_TABLE_ENTRIES];
  int              errors;
  int              words_in;
  int              words_out;
  int              range_errors;
  int              idle_cycles;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{'{12'd1500, 12'd300,  11'd100,  15'd1000,  AREA_MEDIUM}, 1'b0, ST_OK},
    '{'{12'd2000, 12'd2000, 11'd1000, 15'd20000, AREA_METRO},  1'b0, ST_OK},
    '{'{12'd1500, 12'd300,  11'd100,  15'd1000,  AREA_METRO},  1'b0, ST_OK},
    '{'{12'd2000, 12'd2000, 11'd1000, 15'd20000, AREA_MEDIUM}, 1'b0, ST_OK},
    '{'{12'd1800, 12'd500,  11'd150,  15'd5000,  AREA_MEDIUM}, 1'b0, ST_OK},
    '{'{12'd1800, 12'd500,  11'd150,  15'd5000,  AREA_METRO},  1'b0, ST_OK},
    '{'{12'd1500, 12'd2000, 11'd1000, 15'd1000,  AREA_METRO},  1'b0, ST_OK},
    '{'{12'd2000, 12'd300,  11'd100,  15'd20000, AREA_MEDIUM}, 1'b0, ST_OK},
    '{'{12'd1800, 12'd500,  11'd150,  15'd5000,  2'd2},        1'b1, ST_BAD_AREA},
    '{'{12'd0,    12'd0,    11'd0,    15'd0,     2'd3},        1'b1, ST_BAD_AREA},
    '{'{12'd1499, 12'd500,  11'd150,  15'd5000,  AREA_MEDIUM}, 1'b1, ST_BAD_FREQ},
    '{'{12'd2001, 12'd4095, 11'd150,  15'd5000,  AREA_METRO},  1'b1, ST_BAD_FREQ},
    '{'{12'd0,    12'd500,  11'd150,  15'd5000,  AREA_MEDIUM}, 1'b1, ST_BAD_FREQ},
    '{'{12'd4095, 12'd500,  11'd150,  15'd5000,  AREA_MEDIUM}, 1'b1, ST_BAD_FREQ},
    '{'{12'd1800, 12'd299,  11'd150,  15'd5000,  AREA_MEDIUM}, 1'b1, ST_BAD_BASE},
    '{'{12'd1800, 12'd2001, 11'd2047, 15'd5000,  AREA_METRO},  1'b1, ST_BAD_BASE},
    '{'{12'd1800, 12'd4095, 11'd150,  15'd5000,  AREA_MEDIUM}, 1'b1, ST_BAD_BASE},
    '{'{12'd1800, 12'd500,  11'd99,   15'd5000,  AREA_MEDIUM}, 1'b1, ST_BAD_MOBILE},
    '{'{12'd1800, 12'd500,  11'd1001, 15'd5000,  AREA_MEDIUM}, 1'b1, ST_BAD_MOBILE},
    '{'{12'd1800, 12'd500,  11'd2047, 15'd32767, AREA_METRO},  1'b1, ST_BAD_MOBILE},
    '{'{12'd1800, 12'd500,  11'd150,  15'd999,   AREA_MEDIUM}, 1'b1, ST_BAD_DIST},
    '{'{12'd1800, 12'd500,  11'd150,  15'd20001, AREA_MEDIUM}, 1'b1, ST_BAD_DIST},
    '{'{12'd1800, 12'd500,  11'd150,  15'd32767, AREA_METRO},  1'b1, ST_BAD_DIST}
  };

  hata_path_loss_top #(
    .LOSS_FRAC_BITS   (LOSS_FRAC_BITS),
    .LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint floor_div(input longint a, input longint d);
    if (a >= 0) return a / d;
    return -((-a + d - 1) / d);
  endfunction

  // Leading-one exponent plus an interpolated mantissa lookup, Q24.
  function automatic longint unsigned log2_q24(input longint unsigned x);
    int              e;
    longint unsigned frac;
    longint unsigned p;
    longint unsigned idx;
    longint unsigned rem;
    longint unsigned lo;
    longint unsigned hi;
    if (x == 0) return 0;
    e = 0;
    while (e < 31 && (x >> (e + 1)) != 0) e++;
    frac = (x << (32 - e)) & 64'hFFFF_FFFF;
    p    = frac * 64'(LOG_TABLE_ENTRIES);
    idx  = p >> 32;
    rem  = p & 64'hFFFF_FFFF;
    if (idx >= 64'(LOG_TABLE_ENTRIES)) idx = 64'(LOG_TABLE_ENTRIES) - 64'd1;
    lo = log2_mant_q24[idx[MANT_AW-1:0]];
    hi = log2_mant_q24[MANT_AW'(idx + 64'd1)];
    return longint'(e) * Q24 + lo + (((hi - lo) * rem) >> 32);
  endfunction

  function automatic longint log10_q24(input longint unsigned x);
    longint unsigned l2;
    l2 = log2_q24(x);
    return longint'((l2 * 64'(LOG10_2_Q30) + (64'd1 << 29)) >> 30);
  endfunction

  // Expected loss and status of one link; sums run in units of 2^-24 / 100 dB.
  function automatic loss_res_t hata_loss(input link_t ln);
    loss_res_t r;
    longint    lf;
    longint    lb;
    longint    ld;
    longint    a1;
    longint    ter;
    longint    a2;
    longint    acc;
    longint    hm;
    longint    dv;
    r.loss   = '0;
    r.status = ST_OK;
    if (ln.area > AREA_METRO) r.status = ST_BAD_AREA;
    else if (ln.freq < FREQ_MIN || ln.freq > FREQ_MAX) r.status = ST_BAD_FREQ;
    else if (ln.base < BASE_MIN || ln.base > BASE_MAX) r.status = ST_BAD_BASE;
    else if (ln.mob < MOB_MIN || ln.mob > MOB_MAX) r.status = ST_BAD_MOBILE;
    else if (ln.dist_m < DIST_MIN || ln.dist_m > DIST_MAX) r.status = ST_BAD_DIST;
    if (r.status != ST_OK) return r;
    hm  = longint'(ln.mob);
    lf  = log10_q24(64'(ln.freq));
    lb  = log10_q24(64'(ln.base)) - Q24;
    ld  = log10_q24(64'(ln.dist_m)) - 3 * Q24;
    a1  = 110 * lf - 70 * Q24;
    ter = floor_div(a1 * hm, 100) - (156 * lf - 80 * Q24);
    acc = 4630 * Q24 + 3390 * lf - 1382 * lb - ter;
    a2  = 4490 * Q24 - 655 * lb;
    acc = acc + floor_div(a2 * ld, Q24);
    if (ln.area == AREA_METRO) acc = acc + 300 * Q24;
    dv  = 100 * (longint'(1) << (24 - LOSS_FRAC_BITS));
    acc = floor_div(acc + dv / 2, dv);
    if (acc < 0) r.loss = '0;
    else if (acc > 65535) r.loss = 16'hFFFF;
    else r.loss = acc[15:0];
    return r;
  endfunction

  function automatic int unsigned pick_in(input int unsigned lo, input int unsigned hi);
    case ($urandom_range(0, 15))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  function automatic int unsigned pick_out(input int unsigned lo, input int unsigned hi,
                                           input int unsigned top);
    case ($urandom_range(0, 5))
      0:       return lo - 1;
      1:       return hi + 1;
      2:       return $urandom_range(0, lo - 1);
      default: return $urandom_range(hi + 1, top);
    endcase
  endfunction

  // Mostly in-range links, some with one operand out of range, the rest pure noise.
  function automatic link_t random_link();
    link_t       ln;
    int unsigned r;
    logic [63:0] noise;
    r         = $urandom_range(0, 99);
    ln.freq   = 12'(pick_in(32'(FREQ_MIN), 32'(FREQ_MAX)));
    ln.base   = 12'(pick_in(32'(BASE_MIN), 32'(BASE_MAX)));
    ln.mob    = 11'(pick_in(32'(MOB_MIN), 32'(MOB_MAX)));
    ln.dist_m = 15'(pick_in(32'(DIST_MIN), 32'(DIST_MAX)));
    ln.area   = 2'($urandom_range(0, 1));
    if (r >= 90) begin
      noise = {$urandom, $urandom};
      ln    = noise[$bits(link_t)-1:0];
    end else if (r >= 72) begin
      case ($urandom_range(0, 4))
        0:       ln.area   = 2'($urandom_range(2, 3));
        1:       ln.freq   = 12'(pick_out(32'(FREQ_MIN), 32'(FREQ_MAX), 4095));
        2:       ln.base   = 12'(pick_out(32'(BASE_MIN), 32'(BASE_MAX), 4095));
        3:       ln.mob    = 11'(pick_out(32'(MOB_MIN), 32'(MOB_MAX), 2047));
        default: ln.dist_m = 15'(pick_out(32'(DIST_MIN), 32'(DIST_MAX), 32767));
      endcase
    end
    return ln;
  endfunction

  function automatic int unsigned sender_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic offer_link(input link_t ln, input loss_res_t want);
    s_axis_tdata  <= {6'd0, ln.dist_m, ln.mob, ln.base, ln.freq};
    s_axis_tuser  <= ln.area;
    s_axis_tvalid <= 1'b1;
    offered_loss  <= want;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // An edge passes before the first check, so the word accepted at the previous edge is already queued.
  task automatic wait_empty();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_losses.size() != 0) @(posedge clk_i);
  endtask

  // Scoreboard: expectations enter with accepted input words, leave with output words.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pending_losses.push_back(offered_loss);
        words_in++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        words_out++;
        if (m_axis_tuser != ST_OK) range_errors++;
        if (pending_losses.size() == 0) begin
          $display("%0t: unexpected word loss=%0d status=%0d", $time,
                   m_axis_tdata, m_axis_tuser);
          errors++;
        end else begin
          seen = pending_losses.pop_front();
          if (m_axis_tdata !== seen.loss) begin
            $display("%0t: loss mismatch, expected %0d, actual %0d", $time,
                     seen.loss, m_axis_tdata);
            errors++;
          end
          if (m_axis_tuser !== seen.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                     seen.status, m_axis_tuser);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("hata_path_loss_top regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: runs of ready and stalls of random length, plus one long hold-off.
  initial begin
    int hold_left;
    int run_left;
    int stall_left;
    int unsigned r;
    bit hold_done;
    hold_left     = 0;
    run_left      = 0;
    stall_left    = 0;
    hold_done     = 1'b0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!hold_done && hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (run_left > 0) begin
        m_axis_tready <= 1'b1;
        run_left--;
      end else if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 12);
        r = $urandom_range(0, 99);
        if (r < 50) stall_left = 0;
        else if (r < 90) stall_left = $urandom_range(1, 3);
        else stall_left = $urandom_range(10, 50);
        m_axis_tready <= 1'b1;
        run_left--;
      end
    end
  end

  initial begin
    longint unsigned y;
    int unsigned     bits;
    loss_res_t       want;
    link_t           ln;
    int unsigned     gap;
    errors        = 0;
    words_in      = 0;
    words_out     = 0;
    range_errors  = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    offered_loss  <= '0;
    hold_req      <= 1'b0;

    // Mantissa table log2(1 + i/N) in Q24 by repeated squaring.
    for (int i = 0; i < LOG_TABLE_ENTRIES; i++) begin
      y    = (64'd1 << 30) + ((longint'(i) << 30) / LOG_TABLE_ENTRIES);
      bits = 0;
      for (int k = 0; k < 24; k++) begin
        y    = (y * y) >> 30;
        bits = bits << 1;
        if (y >= (64'd1 << 31)) begin
          bits = bits | 1;
          y    = y >> 1;
        end
      end
      log2_mant_q24[i] = 64'(bits);
    end
    log2_mant_q24[LOG_TABLE_ENTRIES] = Q24;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].typed) begin
        want.loss   = '0;
        want.status = dir_rows[i].status;
      end else begin
        want = hata_loss(dir_rows[i].ln);
      end
      offer_link(dir_rows[i].ln, want);
      gap = sender_gap();
      if (gap > 0) pause_sender(gap);
    end
    wait_empty();

    for (int n = 0; n < RANDOM_LINKS; n++) begin
      if (n == QUIET_AT) wait_empty();
      if (n == BURST_FIRST + 20) hold_req <= 1'b1;
      ln = random_link();
      offer_link(ln, hata_loss(ln));
      // The sender offers back to back around the hold-off so the pipeline fills.
      if (n < BURST_FIRST || n > BURST_LAST) begin
        gap = sender_gap();
        if (gap > 0) pause_sender(gap);
      end
    end
    wait_empty();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (pending_losses.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, pending_losses.size());
      errors++;
    end
    $display("Ran %0d links (%0d directed, %0d random) through the loss pipeline.",
             words_in, DIR_ROWS, RANDOM_LINKS);
    $display("Checked %0d results, %0d of them range errors, with %0d mismatches.",
             words_out, range_errors, errors);
    if (errors == 0) begin
      $display("hata_path_loss_top regression: pass");
    end else begin
      $display("hata_path_loss_top regression: fail");
    end
    $finish;
  end

endmodule
